### hw/rtl/scba_pkg.sv
// shared constants, codes, class tables and interface structs of the block allocator
package scba_pkg;

    localparam int NUM_CLASSES = 6;
    localparam int MAX_BLOCKS  = 16;
    localparam int ADDR_BITS   = 14;

    localparam int CLASS_SLOTS = 8;

    localparam int CLS_W = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
    localparam int IDX_W = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
    localparam int CNT_W = $clog2(MAX_BLOCKS + 1);

    // fixed field widths
    localparam int CMD_W    = 2;
    localparam int SIZE_W   = 16;
    localparam int QCLS_W   = 3;
    localparam int STATUS_W = 3;
    localparam int BYTES_W  = 11;
    localparam int CAP_W    = 5;
    localparam int CTR_W    = 32;
    localparam int TOTAL_W  = 14;

    localparam int SIZE_TABLE [CLASS_SLOTS]  = '{32, 64, 128, 256, 512, 1024, 0, 0};
    localparam int COUNT_TABLE [CLASS_SLOTS] = '{16, 16, 16, 12, 8, 4, 0, 0};

    typedef enum logic [CMD_W-1:0] {
        CMD_ALLOC = 2'd0,
        CMD_FREE  = 2'd1,
        CMD_QUERY = 2'd2
    } command_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK           = 3'd0,
        ST_EMPTY        = 3'd1,
        ST_TOO_LARGE    = 3'd2,
        ST_FREE_IGNORED = 3'd3,
        ST_BAD_CLASS    = 3'd4
    } status_t;

    // blocks in class c, clipped to the stack depth
    function automatic int class_count(int c);
        int n;
        n = (c < NUM_CLASSES && c < CLASS_SLOTS) ? COUNT_TABLE[c] : 0;
        if (n > MAX_BLOCKS)
        begin
            n = MAX_BLOCKS;
        end
        return n;
    endfunction

    // classes sit back to back from offset zero
    function automatic int class_base(int c);
        int b;
        b = 0;
        for (int k = 0; k < c; k++)
        begin
            b = b + class_count(k) * SIZE_TABLE[k];
        end
        return b;
    endfunction

    function automatic int class_shift(int c);
        return $clog2(SIZE_TABLE[c]);
    endfunction

    typedef struct packed {
        logic             alloc;
        logic             free;
        logic             hit;
        logic [CLS_W-1:0] cls;
        logic [IDX_W-1:0] free_idx;
    } dec_t;

    typedef struct packed {
        logic             push;
        logic             pop;
        logic [CLS_W-1:0] cls;
        logic [IDX_W-1:0] idx;
    } stack_op_t;

    typedef struct packed {
        logic             alloc_ok;
        logic             free_ok;
        logic             fail;
        logic [CLS_W-1:0] cls;
    } stat_op_t;

    typedef struct packed {
        logic [CNT_W-1:0]   used;
        logic [CNT_W-1:0]   peak;
        logic [CTR_W-1:0]   allocs;
        logic [CTR_W-1:0]   frees;
        logic [CTR_W-1:0]   fails;
        logic [TOTAL_W-1:0] bytes_now;
        logic [TOTAL_W-1:0] bytes_high;
    } stat_view_t;

endpackage

### hw/rtl/size_class_block_allocator.sv
// top level of the size-class block allocator: input register, update logic, result register
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+-------------------------------------------
//   in      | in        | in_valid / in_ready   | command, request_size, block_address,
//           |           |                      | class_index
//   out     | out       | out_valid / out_ready | status, granted_address, class fields,
//           |           |                      | fail_total, bytes_in_use, bytes_high_mark
//
// one item per cycle while out_ready does not hold the result register: an item waits in
// the input register, is decoded there, updates the free stacks and counters, and its
// result is registered; out_valid rises when the result register takes it.
// reset fills every free stack (highest block on top) and clears all counters at once.
// when the result register is held by out_ready low, the input register holds its item
// and in_ready drops only if both are occupied.
module size_class_block_allocator (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [scba_pkg::CMD_W-1:0]      command,
    input  logic [scba_pkg::SIZE_W-1:0]     request_size,
    input  logic [scba_pkg::ADDR_BITS-1:0]  block_address,
    input  logic [scba_pkg::QCLS_W-1:0]     class_index,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [scba_pkg::STATUS_W-1:0]   status,
    output logic [scba_pkg::ADDR_BITS-1:0]  granted_address,
    output logic [scba_pkg::BYTES_W-1:0]    block_bytes,
    output logic [scba_pkg::CAP_W-1:0]      class_capacity,
    output logic [scba_pkg::CAP_W-1:0]      class_used,
    output logic [scba_pkg::CAP_W-1:0]      class_peak,
    output logic [scba_pkg::CTR_W-1:0]      class_allocs,
    output logic [scba_pkg::CTR_W-1:0]      class_frees,
    output logic [scba_pkg::CTR_W-1:0]      fail_total,
    output logic [scba_pkg::TOTAL_W-1:0]    bytes_in_use,
    output logic [scba_pkg::TOTAL_W-1:0]    bytes_high_mark
);
    import scba_pkg::*;

    logic                 in_vld_reg;
    logic [CMD_W-1:0]     cmd_reg;
    logic [SIZE_W-1:0]    size_reg;
    logic [ADDR_BITS-1:0] addr_reg;
    logic [QCLS_W-1:0]    qcls_reg;

    logic                 out_vld_reg;
    logic [STATUS_W-1:0]  status_reg;
    logic [ADDR_BITS-1:0] granted_reg;
    logic [BYTES_W-1:0]   bytes_reg;
    logic [CAP_W-1:0]     cap_reg;
    logic [CAP_W-1:0]     used_reg;
    logic [CAP_W-1:0]     peak_reg;
    logic [CTR_W-1:0]     allocs_reg;
    logic [CTR_W-1:0]     frees_reg;
    logic [CTR_W-1:0]     fails_reg;
    logic [TOTAL_W-1:0]   bytes_now_reg;
    logic [TOTAL_W-1:0]   bytes_high_reg;

    logic                 advance;
    dec_t                 dec;
    stack_op_t            stack_op;
    stat_op_t             stat_op;
    stat_view_t           view;
    logic [IDX_W-1:0]     top   [NUM_CLASSES];
    logic [CNT_W-1:0]     depth [NUM_CLASSES];

    logic                 empty;
    logic                 full;
    logic [ADDR_BITS-1:0] grant_addr;
    logic [BYTES_W-1:0]   cls_bytes;
    logic [CAP_W-1:0]     cls_cap;
    logic                 alloc_ok;
    logic                 free_ok;
    status_t              status_next;

    assign advance  = in_vld_reg && (!out_vld_reg || out_ready);
    assign in_ready = !in_vld_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_vld_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            cmd_reg  <= command;
            size_reg <= request_size;
            addr_reg <= block_address;
            qcls_reg <= class_index;
        end
    end

    scba_decode u_decode (
        .command       (cmd_reg),
        .request_size  (size_reg),
        .block_address (addr_reg),
        .class_index   (qcls_reg),
        .dec           (dec)
    );

    // pick the decoded class's stack state and layout constants
    always_comb
    begin
        empty      = 1'b0;
        full       = 1'b0;
        grant_addr = '0;
        cls_bytes  = '0;
        cls_cap    = '0;
        for (int c = 0; c < NUM_CLASSES; c++)
        begin
            if (CLS_W'(c) == dec.cls)
            begin
                empty      = depth[c] == '0;
                full       = depth[c] >= CNT_W'(class_count(c));
                grant_addr = ADDR_BITS'(class_base(c))
                           + (ADDR_BITS'(top[c]) << class_shift(c));
                cls_bytes  = BYTES_W'(SIZE_TABLE[c]);
                cls_cap    = CAP_W'(class_count(c));
            end
        end
    end

    assign alloc_ok = dec.alloc && dec.hit && !empty;
    assign free_ok  = dec.free && dec.hit && !full;

    always_comb
    begin
        stack_op.pop  = advance && alloc_ok;
        stack_op.push = advance && free_ok;
        stack_op.cls  = dec.cls;
        stack_op.idx  = dec.free_idx;

        stat_op.alloc_ok = advance && alloc_ok;
        stat_op.free_ok  = advance && free_ok;
        stat_op.fail     = advance && dec.alloc && !alloc_ok;
        stat_op.cls      = dec.cls;
    end

    scba_stacks u_stacks (
        .clk   (clk),
        .rst_n (rst_n),
        .op    (stack_op),
        .top   (top),
        .depth (depth)
    );

    scba_stats u_stats (
        .clk   (clk),
        .rst_n (rst_n),
        .op    (stat_op),
        .view  (view)
    );

    always_comb
    begin
        priority if (dec.alloc && !dec.hit)
        begin
            status_next = ST_TOO_LARGE;
        end
        else if (dec.alloc && empty)
        begin
            status_next = ST_EMPTY;
        end
        else if (dec.free && !free_ok)
        begin
            status_next = ST_FREE_IGNORED;
        end
        else if (!dec.hit)
        begin
            status_next = ST_BAD_CLASS;
        end
        else
        begin
            status_next = ST_OK;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_vld_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            status_reg     <= status_next;
            granted_reg    <= alloc_ok ? grant_addr : '0;
            bytes_reg      <= dec.hit ? cls_bytes : '0;
            cap_reg        <= dec.hit ? cls_cap : '0;
            used_reg       <= dec.hit ? CAP_W'(view.used) : '0;
            peak_reg       <= dec.hit ? CAP_W'(view.peak) : '0;
            allocs_reg     <= dec.hit ? view.allocs : '0;
            frees_reg      <= dec.hit ? view.frees : '0;
            fails_reg      <= view.fails;
            bytes_now_reg  <= view.bytes_now;
            bytes_high_reg <= view.bytes_high;
        end
    end

    assign out_valid       = out_vld_reg;
    assign status          = status_reg;
    assign granted_address = granted_reg;
    assign block_bytes     = bytes_reg;
    assign class_capacity  = cap_reg;
    assign class_used      = used_reg;
    assign class_peak      = peak_reg;
    assign class_allocs    = allocs_reg;
    assign class_frees     = frees_reg;
    assign fail_total      = fails_reg;
    assign bytes_in_use    = bytes_now_reg;
    assign bytes_high_mark = bytes_high_reg;

`ifndef SYNTHESIS
    a_peak_covers_used: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (class_peak >= class_used && class_used <= class_capacity))
        else $error("class peak or capacity below class usage");

    a_bytes_high_mark: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> bytes_high_mark >= bytes_in_use)
        else $error("bytes high mark below bytes in use");

    a_grant_only_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status != ST_OK) |-> granted_address == '0)
        else $error("granted address set on a failed item");

    a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        (in_vld_reg && out_valid && !out_ready) |-> !in_ready)
        else $error("input taken while both stages are held");
`endif

endmodule

### hw/rtl/scba_decode.sv
// command decode: size to class, address to class and block index, query class check
module scba_decode (
    input  logic [scba_pkg::CMD_W-1:0]     command,
    input  logic [scba_pkg::SIZE_W-1:0]    request_size,
    input  logic [scba_pkg::ADDR_BITS-1:0] block_address,
    input  logic [scba_pkg::QCLS_W-1:0]    class_index,
    output scba_pkg::dec_t                 dec
);
    import scba_pkg::*;

    logic             a_found;
    logic [CLS_W-1:0] a_cls;
    logic             f_found;
    logic [CLS_W-1:0] f_cls;
    logic [IDX_W-1:0] f_idx;
    logic [31:0]      addr32;
    logic [31:0]      size32;

    always_comb
    begin
        size32  = 32'(request_size);
        addr32  = 32'(block_address);
        a_found = 1'b0;
        a_cls   = '0;
        f_found = 1'b0;
        f_cls   = '0;
        f_idx   = '0;

        // smallest class that fits, no fall-through later
        for (int c = 0; c < NUM_CLASSES; c++)
        begin
            if (!a_found && size32 <= 32'(SIZE_TABLE[c]))
            begin
                a_found = 1'b1;
                a_cls   = CLS_W'(c);
            end
        end

        for (int c = 0; c < NUM_CLASSES; c++)
        begin
            if (!f_found && class_count(c) != 0
                && addr32 >= 32'(class_base(c))
                && addr32 < 32'(class_base(c) + class_count(c) * SIZE_TABLE[c]))
            begin
                f_found = 1'b1;
                f_cls   = CLS_W'(c);
                f_idx   = IDX_W'((addr32 - 32'(class_base(c))) >> class_shift(c));
            end
        end

        dec = '0;
        unique case (command)
            CMD_ALLOC:
            begin
                dec.alloc = 1'b1;
                dec.hit   = a_found;
                dec.cls   = a_cls;
            end
            CMD_FREE:
            begin
                dec.free     = 1'b1;
                dec.hit      = f_found;
                dec.cls      = f_cls;
                dec.free_idx = f_idx;
            end
            CMD_QUERY:
            begin
                dec.hit = 32'(class_index) < 32'(NUM_CLASSES);
                dec.cls = dec.hit ? CLS_W'(class_index) : '0;
            end
            default:
            begin
                dec = '0;
            end
        endcase
    end

endmodule

### hw/rtl/scba_stacks.sv
// per-class lifo free lists as shift stacks, top of each stack at position zero
module scba_stacks (
    input  logic                          clk,
    input  logic                          rst_n,
    input  scba_pkg::stack_op_t           op,
    output logic [scba_pkg::IDX_W-1:0]    top   [scba_pkg::NUM_CLASSES],
    output logic [scba_pkg::CNT_W-1:0]    depth [scba_pkg::NUM_CLASSES]
);
    import scba_pkg::*;

    logic [IDX_W-1:0] stack_reg  [NUM_CLASSES][MAX_BLOCKS];
    logic [IDX_W-1:0] stack_next [NUM_CLASSES][MAX_BLOCKS];
    logic [CNT_W-1:0] depth_reg  [NUM_CLASSES];
    logic [CNT_W-1:0] depth_next [NUM_CLASSES];

    // full stack after reset, highest block on top
    function automatic logic [IDX_W-1:0] stack_init(int c, int k);
        return (k < class_count(c)) ? IDX_W'(class_count(c) - 1 - k) : '0;
    endfunction

    always_comb
    begin
        stack_next = stack_reg;
        depth_next = depth_reg;
        for (int c = 0; c < NUM_CLASSES; c++)
        begin
            if (CLS_W'(c) == op.cls)
            begin
                if (op.pop)
                begin
                    for (int k = 0; k < MAX_BLOCKS - 1; k++)
                    begin
                        stack_next[c][k] = stack_reg[c][k + 1];
                    end
                    depth_next[c] = depth_reg[c] - CNT_W'(1);
                end
                else if (op.push)
                begin
                    stack_next[c][0] = op.idx;
                    for (int k = 1; k < MAX_BLOCKS; k++)
                    begin
                        stack_next[c][k] = stack_reg[c][k - 1];
                    end
                    depth_next[c] = depth_reg[c] + CNT_W'(1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int c = 0; c < NUM_CLASSES; c++)
            begin
                depth_reg[c] <= CNT_W'(class_count(c));
                for (int k = 0; k < MAX_BLOCKS; k++)
                begin
                    stack_reg[c][k] <= stack_init(c, k);
                end
            end
        end
        else
        begin
            stack_reg <= stack_next;
            depth_reg <= depth_next;
        end
    end

    always_comb
    begin
        for (int c = 0; c < NUM_CLASSES; c++)
        begin
            top[c]   = stack_reg[c][0];
            depth[c] = depth_reg[c];
        end
    end

endmodule

### hw/rtl/scba_stats.sv
// usage, peak and event counters per class and for the whole pool
module scba_stats (
    input  logic                   clk,
    input  logic                   rst_n,
    input  scba_pkg::stat_op_t     op,
    output scba_pkg::stat_view_t   view
);
    import scba_pkg::*;

    logic [CNT_W-1:0]   used_reg    [NUM_CLASSES];
    logic [CNT_W-1:0]   used_next   [NUM_CLASSES];
    logic [CNT_W-1:0]   peak_reg    [NUM_CLASSES];
    logic [CNT_W-1:0]   peak_next   [NUM_CLASSES];
    logic [CTR_W-1:0]   allocs_reg  [NUM_CLASSES];
    logic [CTR_W-1:0]   allocs_next [NUM_CLASSES];
    logic [CTR_W-1:0]   frees_reg   [NUM_CLASSES];
    logic [CTR_W-1:0]   frees_next  [NUM_CLASSES];
    logic [CTR_W-1:0]   fail_reg;
    logic [CTR_W-1:0]   fail_next;
    logic [TOTAL_W-1:0] bytes_now_reg;
    logic [TOTAL_W-1:0] bytes_now_next;
    logic [TOTAL_W-1:0] bytes_high_reg;
    logic [TOTAL_W-1:0] bytes_high_next;
    logic [TOTAL_W-1:0] blk;

    always_comb
    begin
        used_next       = used_reg;
        peak_next       = peak_reg;
        allocs_next     = allocs_reg;
        frees_next      = frees_reg;
        fail_next       = fail_reg + CTR_W'(op.fail);
        bytes_now_next  = bytes_now_reg;
        bytes_high_next = bytes_high_reg;
        blk             = '0;
        view            = '0;

        for (int c = 0; c < NUM_CLASSES; c++)
        begin
            if (CLS_W'(c) == op.cls)
            begin
                blk = TOTAL_W'(SIZE_TABLE[c]);
                if (op.alloc_ok)
                begin
                    used_next[c]   = used_reg[c] + CNT_W'(1);
                    allocs_next[c] = allocs_reg[c] + CTR_W'(1);
                    if (used_next[c] > peak_reg[c])
                    begin
                        peak_next[c] = used_next[c];
                    end
                    bytes_now_next = bytes_now_reg + blk;
                end
                else if (op.free_ok)
                begin
                    if (used_reg[c] != '0)
                    begin
                        used_next[c] = used_reg[c] - CNT_W'(1);
                    end
                    frees_next[c]  = frees_reg[c] + CTR_W'(1);
                    bytes_now_next = (bytes_now_reg >= blk) ? bytes_now_reg - blk : '0;
                end
                view.used   = used_next[c];
                view.peak   = peak_next[c];
                view.allocs = allocs_next[c];
                view.frees  = frees_next[c];
            end
        end

        if (bytes_now_next > bytes_high_reg)
        begin
            bytes_high_next = bytes_now_next;
        end

        view.fails      = fail_next;
        view.bytes_now  = bytes_now_next;
        view.bytes_high = bytes_high_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int c = 0; c < NUM_CLASSES; c++)
            begin
                used_reg[c]   <= '0;
                peak_reg[c]   <= '0;
                allocs_reg[c] <= '0;
                frees_reg[c]  <= '0;
            end
            fail_reg       <= '0;
            bytes_now_reg  <= '0;
            bytes_high_reg <= '0;
        end
        else
        begin
            used_reg       <= used_next;
            peak_reg       <= peak_next;
            allocs_reg     <= allocs_next;
            frees_reg      <= frees_next;
            fail_reg       <= fail_next;
            bytes_now_reg  <= bytes_now_next;
            bytes_high_reg <= bytes_high_next;
        end
    end

endmodule
